// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules.
// Each macro expects the module to have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define GMPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define GMPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/gmps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gmps_pkg;

   localparam int MOTIF_LEN_DEF     = 16;
   localparam int MAX_SEQ_LEN_DEF   = 1024;
   localparam int MAX_SEQUENCES_DEF = 131072;

   localparam int IN_POS      = 16;
   localparam int MANT_W      = 22;
   localparam int EXP_W       = 10;
   localparam int WEIGHT_W    = 32;
   localparam int SCORE_W     = 22;
   localparam int RAND_W      = 16;
   localparam int CFG_W       = 11;
   localparam int POS_W       = 10;
   localparam int SEQ_LEN_RST = 1000;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_BASE   = 3'd3;
   localparam logic [2:0] OP_SCORE  = 3'd4;

   localparam logic [2:0] BASE_OTHER = 3'd4;

   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_SCORE  = 1'b1;

   typedef struct packed {
      logic latch;
      logic clear;
      logic add;
      logic remove;
      logic store;
      logic score_vec;
      logic score_acc;
      logic w_init;
      logic w_mul;
      logic w_norm;
      logic w_acc;
      logic p_init;
      logic p_add;
      logic p_cmp;
      logic o_init;
      logic o_cap;
      logic out_load;
   } gmps_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       last;
      logic       j_last;
      logic       o_last;
      logic       win_last;
      logic       ge;
      logic       out_free;
   } gmps_sts_type;

endpackage
`default_nettype wire

// File: rtl/core/gibbs_motif_profile_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Gibbs motif profile sampler.
// req_* carries one beat per op: clear counts, add or remove a motif, stream
// one sequence base, or score a motif. rsp_* carries a sampled window (after
// the base marked last) or a total score (after the score beat marked last).
// csr_* is an APB-style port; register 0 at byte 0 is sequence_length.
// req_ready is high only while the controller is idle. Clear, add, remove
// and base beats pass through an execute state; a score beat adds an
// accumulate state, and a load state when marked last.
// A last base then runs the sampling pass over the len - MOTIF_LEN + 1
// windows: weighing does one store read and one count multiply per position
// of each window, the scan steps window by window up to the hit or the last
// window, the window readout reads one store entry per output base, and the
// result is then loaded.
// The result sits in an output register; the next beat is accepted while it
// waits. Only a second result arriving before the first is taken holds the
// controller until rsp_ready frees the register.
// Reset clears counts to one, the score accumulator and base index to zero,
// and sets sequence_length to 1000. The stores need no clearing pass.
module gibbs_motif_profile_sampler_unit #(
   parameter int MOTIF_LEN     = gmps_pkg::MOTIF_LEN_DEF,
   parameter int MAX_SEQ_LEN   = gmps_pkg::MAX_SEQ_LEN_DEF,
   parameter int MAX_SEQUENCES = gmps_pkg::MAX_SEQUENCES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_op,
   input  logic [31:0]                   req_motif_bases,
   input  logic [15:0]                   req_motif_valid_mask,
   input  logic [2:0]                    req_seq_base,
   input  logic                          req_last,
   input  logic [gmps_pkg::RAND_W-1:0]   req_rand_fraction,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [gmps_pkg::POS_W-1:0]    rsp_window_position,
   output logic [31:0]                   rsp_sampled_motif,
   output logic [15:0]                   rsp_sampled_mask,
   output logic [gmps_pkg::SCORE_W-1:0]  rsp_total_score,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import gmps_pkg::*;

   logic [CFG_W-1:0] seq_len_ff;
   gmps_cmd_type     cmd;
   gmps_sts_type     sts;

   // register 0 decodes on word address 0; other words read as zero
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= CFG_W'(SEQ_LEN_RST);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
         seq_len_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-CFG_W){1'b0}}, seq_len_ff};

   gmps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gmps_dp #(
      .MOTIF_LEN     (MOTIF_LEN),
      .MAX_SEQ_LEN   (MAX_SEQ_LEN),
      .MAX_SEQUENCES (MAX_SEQUENCES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_op               (req_op),
      .req_motif_bases      (req_motif_bases),
      .req_motif_valid_mask (req_motif_valid_mask),
      .req_seq_base         (req_seq_base),
      .req_last             (req_last),
      .req_rand_fraction    (req_rand_fraction),
      .cfg_len              (seq_len_ff),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_window_position  (rsp_window_position),
      .rsp_sampled_motif    (rsp_sampled_motif),
      .rsp_sampled_mask     (rsp_sampled_mask),
      .rsp_total_score      (rsp_total_score),
      .cmd                  (cmd),
      .sts                  (sts)
   );

endmodule
`default_nettype wire

// File: rtl/core/gmps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gmps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gmps_pkg::gmps_sts_type sts,
   output gmps_pkg::gmps_cmd_type cmd
);
   import gmps_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_EXEC   = 16'h0002,
      S_SCORE  = 16'h0004,
      S_W_INIT = 16'h0008,
      S_W_RD   = 16'h0010,
      S_W_MUL  = 16'h0020,
      S_W_NORM = 16'h0040,
      S_W_ACC  = 16'h0080,
      S_P_INIT = 16'h0100,
      S_P_RD   = 16'h0200,
      S_P_ADD  = 16'h0400,
      S_P_CMP  = 16'h0800,
      S_O_INIT = 16'h1000,
      S_O_RD   = 16'h2000,
      S_O_CAP  = 16'h4000,
      S_OUT    = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (sts.op)
               OP_CLEAR:  cmd.clear  = 1'b1;
               OP_ADD:    cmd.add    = 1'b1;
               OP_REMOVE: cmd.remove = 1'b1;
               OP_BASE: begin
                  cmd.store = 1'b1;
                  if (sts.last) state_in = S_W_INIT;
               end
               OP_SCORE: begin
                  cmd.score_vec = 1'b1;
                  state_in      = S_SCORE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCORE: begin
            cmd.score_acc = 1'b1;
            state_in      = sts.last ? S_OUT : S_IDLE;
         end
         S_W_INIT: begin
            cmd.w_init = 1'b1;
            state_in   = S_W_RD;
         end
         S_W_RD:  state_in = S_W_MUL;
         S_W_MUL: begin
            cmd.w_mul = 1'b1;
            state_in  = S_W_NORM;
         end
         S_W_NORM: begin
            cmd.w_norm = 1'b1;
            state_in   = sts.j_last ? S_W_ACC : S_W_RD;
         end
         S_W_ACC: begin
            cmd.w_acc = 1'b1;
            state_in  = sts.win_last ? S_P_INIT : S_W_RD;
         end
         S_P_INIT: begin
            cmd.p_init = 1'b1;
            state_in   = S_P_RD;
         end
         S_P_RD:  state_in = S_P_ADD;
         S_P_ADD: begin
            cmd.p_add = 1'b1;
            state_in  = S_P_CMP;
         end
         S_P_CMP: begin
            cmd.p_cmp = 1'b1;
            state_in  = (sts.ge || sts.win_last) ? S_O_INIT : S_P_RD;
         end
         S_O_INIT: begin
            cmd.o_init = 1'b1;
            state_in   = S_O_RD;
         end
         S_O_RD:  state_in = S_O_CAP;
         S_O_CAP: begin
            cmd.o_cap = 1'b1;
            state_in  = sts.o_last ? S_OUT : S_O_RD;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `GMPS_ASSERT(a_one_update, $onehot0({cmd.clear, cmd.add, cmd.remove, cmd.store, cmd.score_vec}), "more than one count update at once")
   `GMPS_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == S_EXEC, "accepted beat not executed")

endmodule
`default_nettype wire

// File: rtl/core/gmps_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gmps_dp #(
   parameter int MOTIF_LEN     = gmps_pkg::MOTIF_LEN_DEF,
   parameter int MAX_SEQ_LEN   = gmps_pkg::MAX_SEQ_LEN_DEF,
   parameter int MAX_SEQUENCES = gmps_pkg::MAX_SEQUENCES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    req_op,
   input  logic [31:0]                   req_motif_bases,
   input  logic [15:0]                   req_motif_valid_mask,
   input  logic [2:0]                    req_seq_base,
   input  logic                          req_last,
   input  logic [gmps_pkg::RAND_W-1:0]   req_rand_fraction,
   input  logic [gmps_pkg::CFG_W-1:0]    cfg_len,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_result_kind,
   output logic [gmps_pkg::POS_W-1:0]    rsp_window_position,
   output logic [31:0]                   rsp_sampled_motif,
   output logic [15:0]                   rsp_sampled_mask,
   output logic [gmps_pkg::SCORE_W-1:0]  rsp_total_score,
   input  gmps_pkg::gmps_cmd_type        cmd,
   output gmps_pkg::gmps_sts_type        sts
);
   import gmps_pkg::*;

   localparam int AW    = $clog2(MAX_SEQ_LEN);
   localparam int IW    = $clog2(MAX_SEQ_LEN + 1);
   localparam int CLW   = (IW > CFG_W) ? IW : CFG_W;
   localparam int JW    = $clog2(MOTIF_LEN);
   localparam int CNTW  = $clog2(MAX_SEQUENCES + 2);
   localparam int PW    = MANT_W + CNTW;
   localparam int SHW   = $clog2(CNTW + 1);
   localparam int OUTN  = (MOTIF_LEN < IN_POS) ? MOTIF_LEN : IN_POS;
   localparam int PRODW = MANT_W + RAND_W;
   localparam int CMPW  = PRODW + MANT_W;
   localparam int GSW   = $clog2(MANT_W);
   localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SEQUENCES + 1);
   localparam logic signed [EXP_W+1:0] GE_OFS = (EXP_W+2)'(RAND_W);
   localparam logic signed [EXP_W+1:0] GE_HI  = (EXP_W+2)'(RAND_W + 1);
   localparam logic signed [EXP_W+1:0] GE_LO  = -(EXP_W+2)'(MANT_W);

   function automatic logic [WEIGHT_W-1:0] fx_add(
      input logic [MANT_W-1:0] am, input logic [EXP_W-1:0] ae,
      input logic [MANT_W-1:0] bm, input logic [EXP_W-1:0] be);
      logic [MANT_W-1:0] hm, lm, al;
      logic [EXP_W-1:0]  he, le, d;
      logic [MANT_W:0]   s;
      if (am == '0) return {be, bm};
      if (bm == '0) return {ae, am};
      if (be > ae) begin
         hm = bm; he = be; lm = am; le = ae;
      end else begin
         hm = am; he = ae; lm = bm; le = be;
      end
      d  = he - le;
      al = (d < EXP_W'(MANT_W)) ? (lm >> d) : '0;
      s  = {1'b0, hm} + {1'b0, al};
      if (s[MANT_W]) begin
         s  = s >> 1;
         he = he + 1'b1;
      end
      return {he, s[MANT_W-1:0]};
   endfunction

   // latched input beat
   logic [2:0]        op_q, sb_q;
   logic [31:0]       mb_q;
   logic [15:0]       mk_q;
   logic              last_q;
   logic [RAND_W-1:0] rnd_q;

   logic [CNTW-1:0] cnt_ff [4][MOTIF_LEN];
   logic [2:0]      seq_mem [MAX_SEQ_LEN];
   logic [WEIGHT_W-1:0] wgt_mem [MAX_SEQ_LEN];
   logic [2:0]      seq_rd_ff;
   logic [WEIGHT_W-1:0] wgt_rd_ff;

   logic [IW-1:0]     base_idx_ff;
   logic [AW-1:0]     win_ff;
   logic [JW-1:0]     j_ff;
   logic [MANT_W-1:0] w_m_ff, tot_m_ff, part_m_ff;
   logic [EXP_W-1:0]  w_e_ff, tot_e_ff, part_e_ff;
   logic [PW-1:0]     p_ff;
   logic              skip_ff;
   logic [PRODW-1:0]  prod_ff;
   logic [MOTIF_LEN-1:0] mism_ff;
   logic [SCORE_W-1:0] acc_ff;
   logic [31:0]       bits_ff;
   logic [15:0]       msk_ff;
   logic              rsp_valid_ff;
   logic              kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [31:0]       motif_ff;
   logic [15:0]       mask_ff;
   logic [SCORE_W-1:0] score_ff;

   // motif decode, padded so positions past the input width read as invalid
   logic [2*(MOTIF_LEN+IN_POS)-1:0] mb_pad;
   logic [MOTIF_LEN+IN_POS-1:0]     mk_pad;
   logic [MOTIF_LEN-1:0]            ok_vec;
   logic [1:0]                      base_vec [MOTIF_LEN];
   logic [MOTIF_LEN-1:0]            mism_in;

   always_comb begin
      mb_pad = {{(2*MOTIF_LEN){1'b0}}, mb_q};
      mk_pad = {{MOTIF_LEN{1'b0}}, mk_q};
      for (int j = 0; j < MOTIF_LEN; j++) begin
         ok_vec[j]   = (j < IN_POS) && mk_pad[j];
         base_vec[j] = ok_vec[j] ? mb_pad[2*j +: 2] : 2'd0;
      end
   end

   // consensus with ties going to the lower base code
   always_comb begin
      logic [1:0] cons;
      for (int j = 0; j < MOTIF_LEN; j++) begin
         if (cnt_ff[0][j] >= cnt_ff[1][j] && cnt_ff[0][j] >= cnt_ff[2][j] &&
             cnt_ff[0][j] >= cnt_ff[3][j]) cons = 2'd0;
         else if (cnt_ff[1][j] >= cnt_ff[2][j] && cnt_ff[1][j] >= cnt_ff[3][j]) cons = 2'd1;
         else if (cnt_ff[2][j] >= cnt_ff[3][j]) cons = 2'd2;
         else cons = 2'd3;
         mism_in[j] = !ok_vec[j] || (base_vec[j] != cons);
      end
   end

   // sequence length clamp and last window start
   logic [CLW-1:0] len_ext, len_c;
   logic [AW-1:0]  last_win;
   always_comb begin
      len_ext = CLW'(cfg_len);
      if (len_ext < CLW'(MOTIF_LEN)) len_c = CLW'(MOTIF_LEN);
      else if (len_ext > CLW'(MAX_SEQ_LEN)) len_c = CLW'(MAX_SEQ_LEN);
      else len_c = len_ext;
      last_win = AW'(len_c - CLW'(MOTIF_LEN));
   end

   logic [AW-1:0] seq_ra;
   assign seq_ra = AW'({1'b0, win_ff} + (AW+1)'(j_ff));

   // normalize shift of the product
   logic [SHW-1:0] sh;
   always_comb begin
      sh = '0;
      for (int k = 1; k <= CNTW; k++) begin
         if (p_ff[MANT_W-1+k]) sh = SHW'(k);
      end
   end

   // exact test part * 2^16 >= total * rand
   logic signed [EXP_W+1:0] ex_s, ex_n;
   logic [CMPW-1:0] lhs, rhs;
   logic ge;
   always_comb begin
      ex_s = $signed({2'b00, part_e_ff}) - $signed({2'b00, tot_e_ff}) + GE_OFS;
      ex_n = -ex_s;
      if (ex_s >= 0) begin
         lhs = CMPW'(part_m_ff) << ex_s[GSW-1:0];
         rhs = CMPW'(prod_ff);
      end else begin
         lhs = CMPW'(part_m_ff);
         rhs = CMPW'(prod_ff) << ex_n[GSW-1:0];
      end
      if (prod_ff == '0) ge = 1'b1;
      else if (part_m_ff == '0) ge = 1'b0;
      else if (ex_s >= GE_HI) ge = 1'b1;
      else if (ex_s <= GE_LO) ge = 1'b0;
      else ge = (lhs >= rhs);
   end

   logic [SCORE_W:0] acc_sum;
   assign acc_sum = {1'b0, acc_ff} + (SCORE_W+1)'($countones(mism_ff));

   logic [WEIGHT_W-1:0] tot_sum, part_sum;
   assign tot_sum  = fx_add(tot_m_ff, tot_e_ff, w_m_ff, w_e_ff);
   assign part_sum = fx_add(part_m_ff, part_e_ff, wgt_rd_ff[MANT_W-1:0],
                            wgt_rd_ff[WEIGHT_W-1:MANT_W]);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_q   <= req_op;
         mb_q   <= req_motif_bases;
         mk_q   <= req_motif_valid_mask;
         sb_q   <= req_seq_base;
         last_q <= req_last;
         rnd_q  <= req_rand_fraction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int b = 0; b < 4; b++)
            for (int j = 0; j < MOTIF_LEN; j++) cnt_ff[b][j] <= CNTW'(1);
      end else if (cmd.add || cmd.remove) begin
         for (int j = 0; j < MOTIF_LEN; j++) begin
            if (ok_vec[j]) begin
               if (cmd.add && cnt_ff[base_vec[j]][j] < CNT_MAX)
                  cnt_ff[base_vec[j]][j] <= cnt_ff[base_vec[j]][j] + 1'b1;
               else if (cmd.remove && cnt_ff[base_vec[j]][j] != '0)
                  cnt_ff[base_vec[j]][j] <= cnt_ff[base_vec[j]][j] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && base_idx_ff < IW'(MAX_SEQ_LEN))
         seq_mem[base_idx_ff[AW-1:0]] <= sb_q[2] ? BASE_OTHER : sb_q;
      seq_rd_ff <= seq_mem[seq_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.w_acc) wgt_mem[win_ff] <= {w_e_ff, w_m_ff};
      wgt_rd_ff <= wgt_mem[win_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_idx_ff <= '0;
      end else if (cmd.store) begin
         if (last_q) base_idx_ff <= '0;
         else if (base_idx_ff < IW'(MAX_SEQ_LEN)) base_idx_ff <= base_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.w_init || cmd.w_acc) begin
         w_m_ff <= MANT_W'(1) << (MANT_W - 1);
         w_e_ff <= '0;
      end else if (cmd.w_norm && !skip_ff) begin
         if (p_ff == '0) begin
            w_m_ff <= '0;
            w_e_ff <= '0;
         end else begin
            w_m_ff <= MANT_W'(p_ff >> sh);
            w_e_ff <= w_e_ff + EXP_W'(sh);
         end
      end
      if (cmd.w_mul) begin
         p_ff    <= PW'(w_m_ff * cnt_ff[seq_rd_ff[1:0]][j_ff]);
         skip_ff <= seq_rd_ff[2];
      end
      if (cmd.w_init) begin
         tot_m_ff <= '0;
         tot_e_ff <= '0;
      end else if (cmd.w_acc) begin
         {tot_e_ff, tot_m_ff} <= tot_sum;
      end
      if (cmd.p_init) begin
         prod_ff   <= PRODW'(tot_m_ff * rnd_q);
         part_m_ff <= '0;
         part_e_ff <= '0;
      end else if (cmd.p_add) begin
         {part_e_ff, part_m_ff} <= part_sum;
      end
      if (cmd.w_init || cmd.w_acc || cmd.o_init) j_ff <= '0;
      else if (cmd.w_norm || cmd.o_cap)
         j_ff <= (cmd.w_norm && sts.j_last) ? '0 : j_ff + 1'b1;
      if (cmd.w_init || cmd.p_init) win_ff <= '0;
      else if (cmd.w_acc) win_ff <= win_ff + 1'b1;
      else if (cmd.p_cmp && !ge) win_ff <= (win_ff == last_win) ? '0 : win_ff + 1'b1;
      if (cmd.o_init) begin
         bits_ff <= '0;
         msk_ff  <= '0;
      end else if (cmd.o_cap && !seq_rd_ff[2]) begin
         bits_ff[2*j_ff +: 2] <= seq_rd_ff[1:0];
         msk_ff[j_ff]         <= 1'b1;
      end
      if (cmd.score_vec) mism_ff <= mism_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.score_acc) begin
         acc_ff <= acc_sum[SCORE_W] ? {SCORE_W{1'b1}} : acc_sum[SCORE_W-1:0];
      end else if (cmd.out_load && op_q == OP_SCORE) begin
         acc_ff <= '0;
      end
   end

   // output register: holds a result while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (op_q == OP_SCORE) begin
            kind_ff  <= KIND_SCORE;
            pos_ff   <= '0;
            motif_ff <= '0;
            mask_ff  <= '0;
            score_ff <= acc_ff;
         end else begin
            kind_ff  <= KIND_WINDOW;
            pos_ff   <= POS_W'(win_ff);
            motif_ff <= bits_ff;
            mask_ff  <= msk_ff;
            score_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_window_position = pos_ff;
   assign rsp_sampled_motif   = motif_ff;
   assign rsp_sampled_mask    = mask_ff;
   assign rsp_total_score     = score_ff;

   always_comb begin
      sts.op       = op_q;
      sts.last     = last_q;
      sts.j_last   = (j_ff == JW'(MOTIF_LEN - 1));
      sts.o_last   = (j_ff == JW'(OUTN - 1));
      sts.win_last = (win_ff == last_win);
      sts.ge       = ge;
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   `GMPS_ASSERT(a_idx_bound, base_idx_ff <= IW'(MAX_SEQ_LEN), "base index past store depth")
   `GMPS_ASSERT_NEXT(a_score_clear, cmd.out_load && op_q == OP_SCORE, acc_ff == '0 && rsp_valid_ff, "score result did not clear the accumulator")

endmodule
`default_nettype wire
